// File: rtl/assert_macros.svh
// Assertion helpers used by the face normal back end (trf_back).
// The enclosing module must provide i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TRF_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

`define TRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: rtl/trf_pkg.sv
package trf_pkg;

    localparam int CoordW    = 24;
    localparam int DiffW     = 25;
    localparam int ProdW     = 50;
    localparam int CrossW    = 51;
    localparam int MagW      = 50;
    localparam int NormMagW  = 30;
    localparam int MaxShift  = MagW - NormMagW;
    localparam int ShiftW    = 5;
    localparam int SqW       = 60;
    localparam int SumW      = 62;
    localparam int RootSteps = 31;
    localparam int RootW     = 31;
    localparam int DivSteps  = 16;
    localparam int QuotW     = 16;
    localparam int RemW      = 48;
    localparam int DenW      = 32;
    localparam int OutW      = 16;
    localparam int FracShift = 15;

    localparam int FrontStages = 3;
    localparam int QueueDepth  = 8;
    localparam int QueueAw     = 3;

    localparam logic [QuotW-1:0] UnitQ14 = 16'd16384;

    typedef struct packed {
        logic signed [CrossW-1:0] cx;
        logic signed [CrossW-1:0] cy;
        logic signed [CrossW-1:0] cz;
        logic                     degenerate;
        logic                     mesh_end;
    } t_cross;

    typedef struct packed {
        logic [2:0] neg;
        logic       degenerate;
        logic       mesh_end;
    } t_tag;

endpackage

// File: rtl/trf_front.sv
module trf_front import trf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_take,
    input  logic signed [CoordW-1:0] i_first_x,
    input  logic signed [CoordW-1:0] i_first_y,
    input  logic signed [CoordW-1:0] i_first_z,
    input  logic signed [CoordW-1:0] i_second_x,
    input  logic signed [CoordW-1:0] i_second_y,
    input  logic signed [CoordW-1:0] i_second_z,
    input  logic signed [CoordW-1:0] i_third_x,
    input  logic signed [CoordW-1:0] i_third_y,
    input  logic signed [CoordW-1:0] i_third_z,
    input  logic                     i_mesh_end,
    output logic                     o_push,
    output t_cross                   o_item
);

    logic r_v1, r_v2, r_v3;
    logic signed [DiffW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [ProdW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic r_me1, r_me2;
    t_cross r_item;
    logic signed [CrossW-1:0] n_cx, n_cy, n_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_comb begin
        n_cx = CrossW'(r_p0) - CrossW'(r_p1);
        n_cy = CrossW'(r_p2) - CrossW'(r_p3);
        n_cz = CrossW'(r_p4) - CrossW'(r_p5);
    end

    always_ff @(posedge i_clk) begin
        r_ux  <= DiffW'(i_second_x) - DiffW'(i_first_x);
        r_uy  <= DiffW'(i_second_y) - DiffW'(i_first_y);
        r_uz  <= DiffW'(i_second_z) - DiffW'(i_first_z);
        r_vx  <= DiffW'(i_third_x) - DiffW'(i_first_x);
        r_vy  <= DiffW'(i_third_y) - DiffW'(i_first_y);
        r_vz  <= DiffW'(i_third_z) - DiffW'(i_first_z);
        r_me1 <= i_mesh_end;
        r_p0  <= r_vy * r_uz;
        r_p1  <= r_vz * r_uy;
        r_p2  <= r_vz * r_ux;
        r_p3  <= r_vx * r_uz;
        r_p4  <= r_vx * r_uy;
        r_p5  <= r_vy * r_ux;
        r_me2 <= r_me1;
        r_item.cx         <= n_cx;
        r_item.cy         <= n_cy;
        r_item.cz         <= n_cz;
        r_item.degenerate <= (n_cx == '0) && (n_cy == '0) && (n_cz == '0);
        r_item.mesh_end   <= r_me2;
    end

    assign o_push = r_v3;
    assign o_item = r_item;

endmodule

// File: rtl/trf_queue.sv
module trf_queue import trf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cross i_item,
    output logic   o_valid,
    output t_cross o_item,
    output logic   o_busy
);

    t_cross r_mem [QueueDepth];
    t_cross r_out_item;
    logic   r_out_valid;
    logic [QueueAw-1:0] r_wr, r_rd;
    logic [QueueAw:0]   r_count;
    logic pop;

    assign pop     = (r_count != '0);
    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;
    // Leave room for every request still travelling through the front stages.
    assign o_busy  = (r_count > (QueueAw+1)'(QueueDepth - FrontStages - 1));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
        if (pop) begin
            r_out_item <= r_mem[r_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= pop;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/trf_back.sv
`include "assert_macros.svh"

module trf_back import trf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  t_cross                 i_item,
    output logic                   o_strobe,
    output logic signed [OutW-1:0] o_normal_x,
    output logic signed [OutW-1:0] o_normal_y,
    output logic signed [OutW-1:0] o_normal_z,
    output logic                   o_degenerate,
    output logic                   o_mesh_end_out
);

    localparam logic [MagW-1:0] NormLimit = MagW'(1) << NormMagW;

    // Front stages: magnitude, maximum, normalize, square, sum.
    logic r0_v, r1_v, r2_v, r3_v, r4_v;
    t_tag r0_t, r1_t, r2_t, r3_t, r4_t;
    logic [MagW-1:0]     r0_mag [3];
    logic [MagW-1:0]     r1_mag [3];
    logic [MagW-1:0]     r1_max;
    logic [NormMagW-1:0] r2_a [3];
    logic [NormMagW-1:0] r3_a [3];
    logic [SqW-1:0]      r3_sq [3];
    logic [NormMagW-1:0] r4_a [3];
    logic [SumW-1:0]     r4_sum;
    logic [ShiftW-1:0]   n_s;
    logic [MagW-1:0]     n_max01;

    // Square root pipeline, one result bit per stage.
    logic                r_sv [RootSteps+1];
    t_tag                r_st [RootSteps+1];
    logic [SumW-1:0]     r_sx [RootSteps+1];
    logic [SumW-1:0]     r_sr [RootSteps+1];
    logic [NormMagW-1:0] r_sa [RootSteps+1][3];

    // Restoring divider, one quotient bit per stage in each lane.
    logic             r_dv [DivSteps+1];
    t_tag             r_dt [DivSteps+1];
    logic [DenW-1:0]  r_dd [DivSteps+1];
    logic [RemW-1:0]  r_dr [DivSteps+1][3];
    logic [QuotW-1:0] r_dq [DivSteps+1][3];

    logic [RootW-1:0]      root;
    logic [QuotW-1:0]      sat [3];
    logic signed [OutW-1:0] n_norm [3];

    logic                   r_out_v;
    logic signed [OutW-1:0] r_out_n [3];
    logic                   r_out_deg, r_out_me;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r_sv[0] <= 1'b0;
            r_dv[0] <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r_sv[0] <= r4_v;
            r_dv[0] <= r_sv[RootSteps];
            r_out_v <= r_dv[DivSteps];
        end
    end

    always_comb begin
        n_max01 = (r0_mag[0] > r0_mag[1]) ? r0_mag[0] : r0_mag[1];
        // The smallest shift that brings the largest magnitude under 2^30.
        n_s = '0;
        for (int j = MaxShift; j >= 0; j--) begin
            if ((r1_max >> j) < NormLimit) begin
                n_s = ShiftW'(j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r0_t.neg        <= {i_item.cz[CrossW-1], i_item.cy[CrossW-1], i_item.cx[CrossW-1]};
        r0_t.degenerate <= i_item.degenerate;
        r0_t.mesh_end   <= i_item.mesh_end;
        r0_mag[0] <= MagW'(i_item.cx[CrossW-1] ? -i_item.cx : i_item.cx);
        r0_mag[1] <= MagW'(i_item.cy[CrossW-1] ? -i_item.cy : i_item.cy);
        r0_mag[2] <= MagW'(i_item.cz[CrossW-1] ? -i_item.cz : i_item.cz);
        r1_t   <= r0_t;
        r1_max <= (n_max01 > r0_mag[2]) ? n_max01 : r0_mag[2];
        r2_t   <= r1_t;
        r3_t   <= r2_t;
        r4_t   <= r3_t;
        r4_sum <= SumW'(r3_sq[0]) + SumW'(r3_sq[1]) + SumW'(r3_sq[2]);
        for (int i = 0; i < 3; i++) begin
            r1_mag[i] <= r0_mag[i];
            r2_a[i]   <= NormMagW'(r1_mag[i] >> n_s);
            r3_a[i]   <= r2_a[i];
            r3_sq[i]  <= r2_a[i] * r2_a[i];
            r4_a[i]   <= r3_a[i];
        end
        r_st[0] <= r4_t;
        r_sx[0] <= r4_sum;
        r_sr[0] <= '0;
        for (int i = 0; i < 3; i++) begin
            r_sa[0][i] <= r4_a[i];
        end
    end

    genvar k;
    generate
        for (k = 0; k < RootSteps; k++) begin : g_root
            localparam logic [SumW-1:0] Bit = SumW'(1) << (2 * (RootSteps - 1 - k));
            logic [SumW-1:0] trial;
            assign trial = r_sr[k] + Bit;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sv[k+1] <= 1'b0;
                end else begin
                    r_sv[k+1] <= r_sv[k];
                end
            end

            always_ff @(posedge i_clk) begin
                r_st[k+1] <= r_st[k];
                for (int i = 0; i < 3; i++) begin
                    r_sa[k+1][i] <= r_sa[k][i];
                end
                if (r_sx[k] >= trial) begin
                    r_sx[k+1] <= r_sx[k] - trial;
                    r_sr[k+1] <= (r_sr[k] >> 1) + Bit;
                end else begin
                    r_sx[k+1] <= r_sx[k];
                    r_sr[k+1] <= r_sr[k] >> 1;
                end
            end
        end
    endgenerate

    assign root = RootW'(r_sr[RootSteps]);

    always_ff @(posedge i_clk) begin
        r_dt[0] <= r_st[RootSteps];
        r_dd[0] <= DenW'({root, 1'b0});
        for (int i = 0; i < 3; i++) begin
            r_dr[0][i] <= (RemW'(r_sa[RootSteps][i]) << FracShift) + RemW'(root);
            r_dq[0][i] <= '0;
        end
    end

    genvar d;
    generate
        for (d = 0; d < DivSteps; d++) begin : g_div
            logic [RemW-1:0] trial;
            assign trial = RemW'(r_dd[d]) << (DivSteps - 1 - d);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[d+1] <= 1'b0;
                end else begin
                    r_dv[d+1] <= r_dv[d];
                end
            end

            always_ff @(posedge i_clk) begin
                r_dt[d+1] <= r_dt[d];
                r_dd[d+1] <= r_dd[d];
                for (int i = 0; i < 3; i++) begin
                    if (r_dr[d][i] >= trial) begin
                        r_dr[d+1][i] <= r_dr[d][i] - trial;
                        r_dq[d+1][i] <= {r_dq[d][i][QuotW-2:0], 1'b1};
                    end else begin
                        r_dr[d+1][i] <= r_dr[d][i];
                        r_dq[d+1][i] <= {r_dq[d][i][QuotW-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat[i] = (r_dq[DivSteps][i] > UnitQ14) ? UnitQ14 : r_dq[DivSteps][i];
            if (r_dt[DivSteps].degenerate) begin
                n_norm[i] = '0;
            end else if (r_dt[DivSteps].neg[i]) begin
                n_norm[i] = -$signed(sat[i]);
            end else begin
                n_norm[i] = $signed(sat[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_deg <= r_dt[DivSteps].degenerate;
        r_out_me  <= r_dt[DivSteps].mesh_end;
        for (int i = 0; i < 3; i++) begin
            r_out_n[i] <= n_norm[i];
        end
    end

    assign o_strobe       = r_out_v;
    assign o_normal_x     = r_out_n[0];
    assign o_normal_y     = r_out_n[1];
    assign o_normal_z     = r_out_n[2];
    assign o_degenerate   = r_out_deg;
    assign o_mesh_end_out = r_out_me;

    // A nonzero cross product always leaves a nonzero sum of squares after scaling.
    `TRF_ASSERT_IMPL(a_sum_nonzero, r_sv[0] && !r_st[0].degenerate, r_sx[0] != '0)
    // The divider must finish with a remainder below the divisor.
    `TRF_ASSERT_IMPL(a_div_rem, r_dv[DivSteps] && !r_dt[DivSteps].degenerate, (r_dr[DivSteps][0] < RemW'(r_dd[DivSteps])) && (r_dr[DivSteps][1] < RemW'(r_dd[DivSteps])) && (r_dr[DivSteps][2] < RemW'(r_dd[DivSteps])))
    // No component can exceed the root, so no quotient goes past one.
    `TRF_ASSERT_IMPL(a_quot_unit, r_dv[DivSteps] && !r_dt[DivSteps].degenerate, (r_dq[DivSteps][0] <= UnitQ14) && (r_dq[DivSteps][1] <= UnitQ14) && (r_dq[DivSteps][2] <= UnitQ14))

endmodule

// File: rtl/triangle_face_normal.sv
// Flat face normal of one triangle per request. A request is taken at each clock edge where
// start is high and busy is low; triangles may follow one another in every cycle, and the
// result appears on o_strobe in request order. Most of the pipeline lies in the pipelined
// square root (one root bit per stage) and the three-lane restoring divider (one quotient
// bit per stage). The back end cannot be stalled, so the queue between the front stages
// and the back end stays nearly empty and busy stays low in normal use.
module triangle_face_normal import trf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [CoordW-1:0] i_first_x,
    input  logic signed [CoordW-1:0] i_first_y,
    input  logic signed [CoordW-1:0] i_first_z,
    input  logic signed [CoordW-1:0] i_second_x,
    input  logic signed [CoordW-1:0] i_second_y,
    input  logic signed [CoordW-1:0] i_second_z,
    input  logic signed [CoordW-1:0] i_third_x,
    input  logic signed [CoordW-1:0] i_third_y,
    input  logic signed [CoordW-1:0] i_third_z,
    input  logic                     i_mesh_end,
    output logic                     o_strobe,
    output logic signed [OutW-1:0]   o_normal_x,
    output logic signed [OutW-1:0]   o_normal_y,
    output logic signed [OutW-1:0]   o_normal_z,
    output logic                     o_degenerate,
    output logic                     o_mesh_end_out
);

    logic   take, push, q_valid;
    t_cross push_item, q_item;

    assign take = start && !busy;

    trf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .i_third_x  (i_third_x),
        .i_third_y  (i_third_y),
        .i_third_z  (i_third_z),
        .i_mesh_end (i_mesh_end),
        .o_push     (push),
        .o_item     (push_item)
    );

    trf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_busy  (busy)
    );

    trf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_strobe       (o_strobe),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_degenerate   (o_degenerate),
        .o_mesh_end_out (o_mesh_end_out)
    );

endmodule

// File: tb/triangle_face_normal_tb.sv
module triangle_face_normal_tb;
    import trf_pkg::*;

    typedef struct {
        logic signed [CoordW-1:0] vx [9];
        logic                     mesh_end;
    } t_triangle;

    typedef struct {
        logic signed [OutW-1:0] nx;
        logic signed [OutW-1:0] ny;
        logic signed [OutW-1:0] nz;
        logic                   degenerate;
        logic                   mesh_end;
    } t_normal;

    // One row of the directed table; has_known marks rows with a typed-in normal.
    typedef struct {
        t_triangle tri_in;
        bit        has_known;
        t_normal   known;
    } t_row;

    localparam int Latency    = 59;
    localparam int RandomReqs = 1600;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [CoordW-1:0] coord [9];
    logic                     i_mesh_end;
    logic                     o_strobe;
    logic signed [OutW-1:0]   o_normal_x;
    logic signed [OutW-1:0]   o_normal_y;
    logic signed [OutW-1:0]   o_normal_z;
    logic                     o_degenerate;
    logic                     o_mesh_end_out;

    t_normal pending_normals [$];
    int      mismatch_count;
    bit      stimulus_done;

    triangle_face_normal dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_x      (coord[0]),
        .i_first_y      (coord[1]),
        .i_first_z      (coord[2]),
        .i_second_x     (coord[3]),
        .i_second_y     (coord[4]),
        .i_second_z     (coord[5]),
        .i_third_x      (coord[6]),
        .i_third_y      (coord[7]),
        .i_third_z      (coord[8]),
        .i_mesh_end     (i_mesh_end),
        .o_strobe       (o_strobe),
        .o_normal_x     (o_normal_x),
        .o_normal_y     (o_normal_y),
        .o_normal_z     (o_normal_z),
        .o_degenerate   (o_degenerate),
        .o_mesh_end_out (o_mesh_end_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic longint unsigned root_floor(longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   -= res + bitv;
                res  = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_normal face_normal(t_triangle t);
        t_normal         r;
        longint          u [3];
        longint          v [3];
        longint          c [3];
        longint unsigned a [3];
        longint unsigned peak;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        int              sh;
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'(t.vx[3+i]) - longint'(t.vx[i]);
            v[i] = longint'(t.vx[6+i]) - longint'(t.vx[i]);
        end
        c[0] = v[1]*u[2] - v[2]*u[1];
        c[1] = v[2]*u[0] - v[0]*u[2];
        c[2] = v[0]*u[1] - v[1]*u[0];
        r.mesh_end   = t.mesh_end;
        r.degenerate = (c[0] == 0 && c[1] == 0 && c[2] == 0);
        r.nx = '0;
        r.ny = '0;
        r.nz = '0;
        if (r.degenerate) return r;
        peak = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] = (c[i] < 0) ? longint'(-c[i]) : longint'(c[i]);
            if (a[i] > peak) peak = a[i];
        end
        sh = 0;
        while ((peak >> sh) >= (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            a[i] >>= sh;
            sum += a[i] * a[i];
        end
        len = root_floor(sum);
        for (int i = 0; i < 3; i++) begin
            q = ((a[i] << 15) + len) / (2 * len);
            if (q > 16384) q = 16384;
            if (c[i] < 0) q = -q;
            if (i == 0) r.nx = q[15:0];
            else if (i == 1) r.ny = q[15:0];
            else r.nz = q[15:0];
        end
        return r;
    endfunction

    function automatic t_triangle random_triangle();
        t_triangle t;
        int        mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) begin
            case (mode) inside
                0:       t.vx[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                [1:2]:   t.vx[i] = $signed(24'($urandom_range(0, 63))) - 24'sd32;
                default: t.vx[i] = 24'($urandom);
            endcase
        end
        // Sometimes make C lie on line AB (or coincide) to hit the degenerate path.
        if ($urandom_range(0, 11) == 0) begin
            for (int i = 0; i < 3; i++) begin
                t.vx[3+i] = $signed(24'($urandom_range(0, 255))) - 24'sd128;
                t.vx[i]   = $signed(24'($urandom_range(0, 255))) - 24'sd128;
                t.vx[6+i] = 24'(2*t.vx[3+i] - t.vx[i]);
            end
        end
        t.mesh_end = 1'($urandom_range(0, 1));
        return t;
    endfunction

    function automatic t_triangle make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                           int cx, int cy, int cz, bit me);
        t_triangle t;
        t.vx[0] = 24'(ax); t.vx[1] = 24'(ay); t.vx[2] = 24'(az);
        t.vx[3] = 24'(bx); t.vx[4] = 24'(by); t.vx[5] = 24'(bz);
        t.vx[6] = 24'(cx); t.vx[7] = 24'(cy); t.vx[8] = 24'(cz);
        t.mesh_end = me;
        return t;
    endfunction

    task automatic send_request(t_triangle t);
        for (int i = 0; i < 9; i++) coord[i] <= t.vx[i];
        i_mesh_end <= t.mesh_end;
        start      <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_normals.push_back(face_normal(t));
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                        : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
        if (n > 0) begin
            start <= 1'b0;
            for (int i = 0; i < 9; i++) coord[i] <= 24'($urandom);
            i_mesh_end <= 1'($urandom_range(0, 1));
            repeat (n) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_normal want;
        if (i_rst_n && o_strobe) begin
            if (pending_normals.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected normal at %0t", $realtime);
            end else begin
                want = pending_normals.pop_front();
                if (o_normal_x !== want.nx || o_normal_y !== want.ny ||
                    o_normal_z !== want.nz || o_degenerate !== want.degenerate ||
                    o_mesh_end_out !== want.mesh_end) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("normal mismatch: exp %0d %0d %0d d%0b e%0b got %0d %0d %0d d%0b e%0b",
                                 want.nx, want.ny, want.nz, want.degenerate, want.mesh_end,
                                 o_normal_x, o_normal_y, o_normal_z, o_degenerate,
                                 o_mesh_end_out);
                end
            end
        end
    end

    initial begin
        t_row  rows [$];
        t_row  row;
        int    wait_cycles;
        mismatch_count = 0;
        stimulus_done  = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_mesh_end = 1'b0;
        for (int i = 0; i < 9; i++) coord[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Axis-aligned faces give an exact unit normal; v x u points opposite to u x v.
        row.has_known = 1;
        row.tri_in = make_tri(0,0,0, 65536,0,0, 0,65536,0, 0);
        row.known = '{0, 0, -16384, 0, 0};
        rows.push_back(row);
        row.tri_in = make_tri(0,0,0, 0,65536,0, 65536,0,0, 1);
        row.known = '{0, 0, 16384, 0, 1};
        rows.push_back(row);
        row.tri_in = make_tri(0,0,0, 0,1,0, 0,0,1, 0);
        row.known = '{-16384, 0, 0, 0, 0};
        rows.push_back(row);
        row.tri_in = make_tri(5,5,5, 5,5,6, 6,5,5, 1);
        row.known = '{0, -16384, 0, 0, 1};
        rows.push_back(row);
        // Coincident and collinear vertices, including at the coordinate extremes.
        row.tri_in = make_tri(0,0,0, 0,0,0, 0,0,0, 0);
        row.known = '{0, 0, 0, 1, 0};
        rows.push_back(row);
        row.tri_in = make_tri(-8388608,-8388608,-8388608, 8388607,8388607,8388607,
                              0,0,0, 1);
        row.known = '{0, 0, 0, 1, 1};
        rows.push_back(row);
        row.tri_in = make_tri(1,2,3, 2,4,6, 3,6,9, 0);
        row.known = '{0, 0, 0, 1, 0};
        rows.push_back(row);
        row.has_known = 0;
        row.tri_in = make_tri(-8388608,-8388608,-8388608, 8388607,-8388608,-8388608,
                              -8388608,8388607,8388607, 1);
        rows.push_back(row);
        row.tri_in = make_tri(8388607,8388607,8388607, -8388608,8388607,-8388608,
                              8388607,-8388608,-8388608, 0);
        rows.push_back(row);
        row.tri_in = make_tri(-8388608,8388607,0, 8388607,-8388608,8388607,
                              0,0,-8388608, 1);
        rows.push_back(row);
        row.tri_in = make_tri(0,0,0, 1,0,0, 0,1,1, 0);
        rows.push_back(row);
        row.tri_in = make_tri(0,0,0, 3,1,0, 1,2,5, 1);
        rows.push_back(row);
        row.tri_in = make_tri(-1,-1,-1, 8388607,-8388608,1, 2,3,-8388608, 0);
        rows.push_back(row);

        foreach (rows[k]) begin
            send_request(rows[k].tri_in);
            if (rows[k].has_known) begin
                pending_normals.pop_back();
                pending_normals.push_back(rows[k].known);
            end
        end

        for (int n = 0; n < RandomReqs; n++) begin
            if (n == RandomReqs / 2) begin
                start <= 1'b0;
                while (pending_normals.size() != 0) @(posedge i_clk);
            end
            // Long stretches of back-to-back requests between the gappy ones.
            if ((n / 200) % 2 == 1) idle_gap();
            send_request(random_triangle());
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (pending_normals.size() != 0 && wait_cycles < 100_000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (Latency + 10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_normals.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
